// File: rtl/sng_pkg.sv
`default_nettype none

package sng_pkg;

  localparam int SAMPLE_BITS = 24;
  localparam int HOLD_BITS   = 20;
  localparam int REL_BITS    = 16;
  localparam int THR_BITS    = SAMPLE_BITS + 1;
  localparam int CFG_W       = (THR_BITS > HOLD_BITS) ? THR_BITS : HOLD_BITS;
  localparam int CFG_IDX_W   = 3;
  localparam int STEP_W      = 4;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic [STEP_W-1:0]             step_t;

  // unity gain, Q(SAMPLE_BITS-1)
  localparam logic [SAMPLE_BITS-1:0] ONE  = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
  localparam logic [SAMPLE_BITS-1:0] HALF = {2'b01, {(SAMPLE_BITS-2){1'b0}}};

  localparam logic [SAMPLE_BITS-1:0] ATTACK_RST  = SAMPLE_BITS'(174763);
  localparam logic [SAMPLE_BITS-1:0] DECAY_RST   = SAMPLE_BITS'(87381);
  localparam logic [HOLD_BITS-1:0]   HOLD_RST    = HOLD_BITS'(96);
  localparam logic [REL_BITS-1:0]    RELEASE_RST = REL_BITS'(655);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_THRESHOLD = 3'd0,
    REG_RANGE     = 3'd1,
    REG_ATTACK    = 3'd2,
    REG_DECAY     = 3'd3,
    REG_HOLD      = 3'd4,
    REG_RELEASE   = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic [THR_BITS-1:0]    threshold;
    logic [SAMPLE_BITS-1:0] range;
    logic [SAMPLE_BITS-1:0] attack;
    logic [SAMPLE_BITS-1:0] decay;
    logic [HOLD_BITS-1:0]   hold;
    logic [REL_BITS-1:0]    release_coef;
  } cfg_t;

  typedef enum logic [2:0] {
    MUL_NONE = 3'd0,
    MUL_SC   = 3'd1,
    MUL_EC   = 3'd2,
    MUL_RG   = 3'd3,
    MUL_L    = 3'd4,
    MUL_R    = 3'd5
  } mul_sel_e;

  typedef enum logic [1:0] {
    ACC_HOLD = 2'd0,
    ACC_LOAD = 2'd1,
    ACC_ADD  = 2'd2,
    ACC_GAIN = 2'd3
  } acc_op_e;

  typedef enum logic [2:0] {
    DST_NONE     = 3'd0,
    DST_S        = 3'd1,
    DST_ENV_RISE = 3'd2,
    DST_ENV_FALL = 3'd3,
    DST_GATE     = 3'd4,
    DST_G        = 3'd5,
    DST_LT       = 3'd6,
    DST_OUT      = 3'd7
  } dst_e;

  typedef enum logic [2:0] {
    COND_NEVER    = 3'd0,
    COND_ALWAYS   = 3'd1,
    COND_NO_IN    = 3'd2,
    COND_S_GT_ENV = 3'd3,
    COND_OUT_BUSY = 3'd4
  } cond_e;

  typedef struct packed {
    logic     in_rdy;
    mul_sel_e mul_sel;
    acc_op_e  acc_op;
    dst_e     dst;
    cond_e    cond;
    step_t    target;
  } ctrl_t;

  localparam step_t STEP_IDLE  = 4'd0;
  localparam step_t STEP_ABS   = 4'd1;
  localparam step_t STEP_CMP   = 4'd2;
  localparam step_t STEP_MSC   = 4'd3;
  localparam step_t STEP_MEC   = 4'd4;
  localparam step_t STEP_SUM   = 4'd5;
  localparam step_t STEP_EFALL = 4'd6;
  localparam step_t STEP_GATE  = 4'd7;
  localparam step_t STEP_MRG   = 4'd8;
  localparam step_t STEP_GSUM  = 4'd9;
  localparam step_t STEP_GAIN  = 4'd10;
  localparam step_t STEP_ML    = 4'd11;
  localparam step_t STEP_MR    = 4'd12;
  localparam step_t STEP_WAIT  = 4'd13;
  localparam step_t STEP_OUT   = 4'd14;

  // microcode rom
  function automatic ctrl_t ucode(input step_t step);
    ctrl_t w;
    unique case (step)
      STEP_IDLE:  w = '{1'b1, MUL_NONE, ACC_HOLD, DST_NONE,     COND_NO_IN,    STEP_IDLE};
      STEP_ABS:   w = '{1'b0, MUL_NONE, ACC_HOLD, DST_S,        COND_NEVER,    STEP_IDLE};
      STEP_CMP:   w = '{1'b0, MUL_NONE, ACC_HOLD, DST_ENV_RISE, COND_S_GT_ENV, STEP_GATE};
      STEP_MSC:   w = '{1'b0, MUL_SC,   ACC_HOLD, DST_NONE,     COND_NEVER,    STEP_IDLE};
      STEP_MEC:   w = '{1'b0, MUL_EC,   ACC_LOAD, DST_NONE,     COND_NEVER,    STEP_IDLE};
      STEP_SUM:   w = '{1'b0, MUL_NONE, ACC_ADD,  DST_NONE,     COND_NEVER,    STEP_IDLE};
      STEP_EFALL: w = '{1'b0, MUL_NONE, ACC_HOLD, DST_ENV_FALL, COND_NEVER,    STEP_IDLE};
      STEP_GATE:  w = '{1'b0, MUL_NONE, ACC_HOLD, DST_GATE,     COND_NEVER,    STEP_IDLE};
      STEP_MRG:   w = '{1'b0, MUL_RG,   ACC_HOLD, DST_NONE,     COND_NEVER,    STEP_IDLE};
      STEP_GSUM:  w = '{1'b0, MUL_NONE, ACC_GAIN, DST_NONE,     COND_NEVER,    STEP_IDLE};
      STEP_GAIN:  w = '{1'b0, MUL_NONE, ACC_HOLD, DST_G,        COND_NEVER,    STEP_IDLE};
      STEP_ML:    w = '{1'b0, MUL_L,    ACC_HOLD, DST_NONE,     COND_NEVER,    STEP_IDLE};
      STEP_MR:    w = '{1'b0, MUL_R,    ACC_HOLD, DST_LT,       COND_NEVER,    STEP_IDLE};
      STEP_WAIT:  w = '{1'b0, MUL_NONE, ACC_HOLD, DST_NONE,     COND_OUT_BUSY, STEP_WAIT};
      STEP_OUT:   w = '{1'b0, MUL_NONE, ACC_HOLD, DST_OUT,      COND_ALWAYS,   STEP_IDLE};
      default:    w = '{1'b0, MUL_NONE, ACC_HOLD, DST_NONE,     COND_ALWAYS,   STEP_IDLE};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// File: rtl/sng_if.sv
`default_nettype none

interface sng_in_if import sng_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t left_in;
  sample_t right_in;

  modport source (output valid, output left_in, output right_in, input ready);
  modport sink   (input valid, input left_in, input right_in, output ready);
endinterface

interface sng_out_if import sng_pkg::*; ();
  logic       valid;
  logic       ready;
  sample_t    left_out;
  sample_t    right_out;
  logic [1:0] gate_phase;

  modport source (output valid, output left_out, output right_out, output gate_phase,
                  input ready);
  modport sink   (input valid, input left_out, input right_out, input gate_phase,
                  output ready);
endinterface

`default_nettype wire

// File: rtl/stereo_noise_gate.sv
`default_nettype none

// Stereo noise gate. One sample pair is taken per word on in_if while the sequencer
// sits at its idle step; the gated pair and the gate phase after that pair come out
// as one word on out_if. The microcode program steps one shared 26x26 multiplier
// through the envelope, gain and two output products, and skips the envelope
// products when the input rises above the envelope. The next pair is taken in the
// cycle after the result is written to the output register; if the previous result
// is still not taken, the program waits before that write. The user must write the
// registers through cfg_we_i, cfg_idx_i and cfg_data_i only while no pair is in
// flight; the block does not enforce this. Indexes past the release coefficient
// are dropped.
module stereo_noise_gate import sng_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  sng_in_if.sink               in_if,
  sng_out_if.source            out_if
);

  cfg_t  cfg_q;
  step_t step_q, step_d;
  ctrl_t ctrl;
  logic  out_valid_q;
  logic  in_fire;
  logic  jump;
  logic  s_gt_env;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.threshold    <= {1'b0, ONE};
      cfg_q.range        <= ONE;
      cfg_q.attack       <= ATTACK_RST;
      cfg_q.decay        <= DECAY_RST;
      cfg_q.hold         <= HOLD_RST;
      cfg_q.release_coef <= RELEASE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_THRESHOLD: cfg_q.threshold    <= cfg_data_i[THR_BITS-1:0];
        REG_RANGE:     cfg_q.range        <= cfg_data_i[SAMPLE_BITS-1:0];
        REG_ATTACK:    cfg_q.attack       <= cfg_data_i[SAMPLE_BITS-1:0];
        REG_DECAY:     cfg_q.decay        <= cfg_data_i[SAMPLE_BITS-1:0];
        REG_HOLD:      cfg_q.hold         <= cfg_data_i[HOLD_BITS-1:0];
        REG_RELEASE:   cfg_q.release_coef <= cfg_data_i[REL_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign ctrl    = ucode(step_q);
  assign in_fire = in_if.valid && ctrl.in_rdy;

  always_comb begin
    unique case (ctrl.cond)
      COND_NEVER:    jump = 1'b0;
      COND_ALWAYS:   jump = 1'b1;
      COND_NO_IN:    jump = !in_if.valid;
      COND_S_GT_ENV: jump = s_gt_env;
      COND_OUT_BUSY: jump = out_valid_q && !out_if.ready;
      default:       jump = 1'b1;
    endcase
  end

  assign step_d = jump ? ctrl.target : step_q + 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= STEP_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      step_q <= step_d;
      if (ctrl.dst == DST_OUT) begin
        out_valid_q <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  sng_datapath u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (ctrl),
    .cfg_i      (cfg_q),
    .load_i     (in_fire),
    .left_i     (in_if.left_in),
    .right_i    (in_if.right_in),
    .s_gt_env_o (s_gt_env),
    .left_o     (out_if.left_out),
    .right_o    (out_if.right_out),
    .phase_o    (out_if.gate_phase)
  );

  assign in_if.ready  = ctrl.in_rdy;
  assign out_if.valid = out_valid_q;

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl.dst == DST_OUT) |-> !out_valid_q) else $error("result written over pending word");
  a_out_shown: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl.dst == DST_OUT) |=> out_valid_q) else $error("result not presented");
  a_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (step_q == STEP_ABS)) else $error("program did not start on accept");

endmodule

`default_nettype wire

// File: rtl/sng_datapath.sv
`default_nettype none

module sng_datapath import sng_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  ctrl_t      ctrl_i,
  input  cfg_t       cfg_i,
  input  logic       load_i,
  input  sample_t    left_i,
  input  sample_t    right_i,
  output logic       s_gt_env_o,
  output sample_t    left_o,
  output sample_t    right_o,
  output logic [1:0] phase_o
);

  localparam int SB        = SAMPLE_BITS;
  localparam int MW        = SB + 2;
  localparam int PW        = 2 * MW;
  localparam int ENV_SHIFT = REL_BITS;

  localparam logic signed [PW-1:0] QMAX = (PW'(1) << (SB - 1)) - PW'(1);
  localparam logic signed [PW-1:0] QMIN = ~QMAX;
  localparam logic [SB:0]          ONE_X = {1'b0, ONE};

  typedef enum logic [3:0] {
    PH_CLOSED  = 4'b0001,
    PH_OPENING = 4'b0010,
    PH_OPEN    = 4'b0100,
    PH_CLOSING = 4'b1000
  } phase_e;

  localparam logic [1:0] CODE_CLOSED  = 2'd0;
  localparam logic [1:0] CODE_OPENING = 2'd1;
  localparam logic [1:0] CODE_OPEN    = 2'd2;
  localparam logic [1:0] CODE_CLOSING = 2'd3;

  function automatic logic [1:0] phase_code(input phase_e ph);
    logic [1:0] c;
    unique case (ph)
      PH_CLOSED:  c = CODE_CLOSED;
      PH_OPENING: c = CODE_OPENING;
      PH_OPEN:    c = CODE_OPEN;
      PH_CLOSING: c = CODE_CLOSING;
      default:    c = CODE_CLOSED;
    endcase
    return c;
  endfunction

  // round half up, floor toward minus infinity, then clamp
  function automatic sample_t sat_round(input logic signed [PW-1:0] p);
    logic signed [PW-1:0] q;
    sample_t r;
    q = (p + $signed(PW'(HALF))) >>> (SB - 1);
    if (q > QMAX) begin
      r = QMAX[SB-1:0];
    end else if (q < QMIN) begin
      r = QMIN[SB-1:0];
    end else begin
      r = q[SB-1:0];
    end
    return r;
  endfunction

  sample_t              l_q, r_q, lt_q, out_l_q, out_r_q;
  logic [1:0]           out_ph_q;
  logic [SB:0]          s_q, env_q, env_d;
  logic [SB-1:0]        gl_q, gl_d, g_q;
  logic [HOLD_BITS-1:0] hold_q, hold_d;
  phase_e               phase_q, phase_d;
  logic signed [PW-1:0] prod_q, acc_q, acc_d;
  logic signed [MW-1:0] mul_a, mul_b;

  logic [SB:0]          abs_l, abs_r, l_x, r_x;
  logic [REL_BITS:0]    nc;
  logic [SB-1:0]        rg;
  logic [SB:0]          one_m_gl;
  logic [SB:0]          gl_sum;
  logic [SB-1:0]        gl_dec;
  logic                 thr_hit;

  assign l_x   = {l_q[SB-1], l_q};
  assign r_x   = {r_q[SB-1], r_q};
  assign abs_l = l_x[SB] ? (~l_x + 1'b1) : l_x;
  assign abs_r = r_x[SB] ? (~r_x + 1'b1) : r_x;

  assign s_gt_env_o = s_q > env_q;

  assign nc       = {1'b1, {REL_BITS{1'b0}}} - {1'b0, cfg_i.release_coef};
  assign rg       = (cfg_i.range > ONE) ? ONE : cfg_i.range;
  assign one_m_gl = ONE_X - {1'b0, gl_q};

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (ctrl_i.mul_sel)
      MUL_SC: begin
        mul_a = MW'(s_q);
        mul_b = MW'(cfg_i.release_coef);
      end
      MUL_EC: begin
        mul_a = MW'(env_q);
        mul_b = MW'(nc);
      end
      MUL_RG: begin
        mul_a = MW'(rg);
        mul_b = MW'(one_m_gl);
      end
      MUL_L: begin
        mul_a = MW'(l_q);
        mul_b = MW'(g_q);
      end
      MUL_R: begin
        mul_a = MW'(r_q);
        mul_b = MW'(g_q);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    acc_d = acc_q;
    unique case (ctrl_i.acc_op)
      ACC_HOLD: acc_d = acc_q;
      ACC_LOAD: acc_d = prod_q;
      ACC_ADD:  acc_d = acc_q + prod_q;
      ACC_GAIN: acc_d = prod_q + $signed(PW'({gl_q, {(SB-1){1'b0}}}))
                        + $signed(PW'(HALF));
      default:  acc_d = acc_q;
    endcase
  end

  // gate phase update, envelope already current
  assign thr_hit = env_q >= cfg_i.threshold;
  assign gl_sum  = {1'b0, gl_q} + {1'b0, cfg_i.attack};
  assign gl_dec  = (gl_q > cfg_i.decay) ? (gl_q - cfg_i.decay) : '0;

  always_comb begin
    env_d   = env_q;
    gl_d    = gl_q;
    hold_d  = hold_q;
    phase_d = phase_q;
    unique case (ctrl_i.dst)
      DST_ENV_RISE: begin
        if (s_gt_env_o) begin
          env_d = s_q;
        end
      end
      DST_ENV_FALL: env_d = acc_q[ENV_SHIFT +: SB+1];
      DST_GATE: begin
        unique case (phase_q)
          PH_CLOSED: begin
            if (thr_hit) begin
              phase_d = PH_OPENING;
            end
          end
          PH_OPENING: begin
            if (gl_sum >= ONE_X) begin
              gl_d    = ONE;
              phase_d = PH_OPEN;
              hold_d  = cfg_i.hold;
            end else begin
              gl_d = gl_sum[SB-1:0];
            end
          end
          PH_OPEN: begin
            if (hold_q == '0) begin
              if (!thr_hit) begin
                phase_d = PH_CLOSING;
              end
            end else begin
              hold_d = hold_q - 1'b1;
            end
          end
          PH_CLOSING: begin
            gl_d = gl_dec;
            if (thr_hit) begin
              phase_d = PH_OPENING;
            end else if (gl_dec == '0) begin
              phase_d = PH_CLOSED;
            end
          end
          default: phase_d = PH_CLOSED;
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      env_q   <= '0;
      gl_q    <= '0;
      hold_q  <= '0;
      phase_q <= PH_CLOSED;
    end else begin
      env_q   <= env_d;
      gl_q    <= gl_d;
      hold_q  <= hold_d;
      phase_q <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      l_q <= left_i;
      r_q <= right_i;
    end
    if (ctrl_i.dst == DST_S) begin
      s_q <= abs_l + abs_r;
    end
    if (ctrl_i.mul_sel != MUL_NONE) begin
      prod_q <= mul_a * mul_b;
    end
    acc_q <= acc_d;
    if (ctrl_i.dst == DST_G) begin
      g_q <= acc_q[SB-1 +: SB];
    end
    if (ctrl_i.dst == DST_LT) begin
      lt_q <= sat_round(prod_q);
    end
    if (ctrl_i.dst == DST_OUT) begin
      out_l_q  <= lt_q;
      out_r_q  <= sat_round(prod_q);
      out_ph_q <= phase_code(phase_q);
    end
  end

  assign left_o  = out_l_q;
  assign right_o = out_r_q;
  assign phase_o = out_ph_q;

  a_gl_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    gl_q <= ONE) else $error("gate level above unity");
  a_open_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_OPEN) |-> (gl_q == ONE)) else $error("open gate not at unity");
  a_closed_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_CLOSED) |-> (gl_q == '0)) else $error("closed gate not at zero");

endmodule

`default_nettype wire
